// ===== src/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared widths, request and status codes, and the command and status words
// that pass between the table controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

   localparam int CAPACITY_DEF = 128;

   localparam int REQ_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 7;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 8;

   localparam logic [REQ_W-1:0] REQ_APPEND        = 3'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND_ABSENT = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE        = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FIND          = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ          = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR         = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

   typedef struct packed {
      logic load;     // capture the accepted request
      logic scan;     // walk the table looking for the value
      logic shift;    // move later entries down by one
      logic dec;      // drop the count by one after a removal
      logic append;   // store the value at the end if there is room
      logic read;     // read the entry at the requested index
      logic clear;    // empty the table
      logic finish;   // load the result register
   } bst_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_code;
      logic             scan_done;
      logic             scan_hit;
      logic             shift_done;
      logic             out_free;
   } bst_stat_type;

endpackage

`default_nettype wire

// ===== src/bounded_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table
// Ordered list of signed 32-bit values in a table of CAPACITY entries with a
// count: append, append if absent, remove, find, read at index and clear.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid/req_ready    req_type, req_value, req_index
//   rsp_      out        rsp_valid/rsp_ready    rsp_status, rsp_present,
//                                                rsp_position, rsp_entry_value,
//                                                rsp_entry_count
//
// One request is in flight at a time. Append, read and clear need no walk;
// find, append-if-absent and remove walk the single table memory, one entry
// a cycle, over at most count entries. Synchronous reset empties the table by
// clearing the count; the memory itself is not swept. A stalled result waits
// in the output register, and the block waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_table import bst_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire  logic                       clock,
   input  wire  logic                       reset,
   input  wire  logic                       req_valid,
   output logic                             req_ready,
   input  wire  logic [REQ_W-1:0]           req_type,
   input  wire  logic signed [VALUE_W-1:0]  req_value,
   input  wire  logic [INDEX_W-1:0]         req_index,
   output logic                             rsp_valid,
   input  wire  logic                       rsp_ready,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic                             rsp_present,
   output logic [POS_W-1:0]                 rsp_position,
   output logic signed [VALUE_W-1:0]        rsp_entry_value,
   output logic [COUNT_W-1:0]               rsp_entry_count
);

   bst_cmd_type  cmd;
   bst_stat_type stat;

   bst_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   bst_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_present     (rsp_present),
      .rsp_position    (rsp_position),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

`default_nettype wire

// ===== src/bst_ram.sv =====
// ----------------------------------------------------------------------------
// bst_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic                     rd_en,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/bst_datapath.sv =====
// ----------------------------------------------------------------------------
// bst_datapath
// Request and result registers, entry count, walk pointer and the table
// memory, driven by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_datapath import bst_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire  logic                       clock,
   input  wire  logic                       reset,
   input  wire  bst_cmd_type                cmd,
   output bst_stat_type                     stat,
   input  wire  logic [REQ_W-1:0]           req_type,
   input  wire  logic signed [VALUE_W-1:0]  req_value,
   input  wire  logic [INDEX_W-1:0]         req_index,
   output logic                             rsp_valid,
   input  wire  logic                       rsp_ready,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic                             rsp_present,
   output logic [POS_W-1:0]                 rsp_position,
   output logic signed [VALUE_W-1:0]        rsp_entry_value,
   output logic [COUNT_W-1:0]               rsp_entry_count
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [REQ_W-1:0]   type_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0] index_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_pos_ff, pend_pos_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_pos_ff, hit_pos_in;
   logic          full_ff, full_in;
   logic [AW-1:0] app_pos_ff, app_pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                present_ff, present_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [VALUE_W-1:0]  entry_ff, entry_in;
   logic [COUNT_W-1:0]  ecount_ff;

   logic               mem_wr_en, mem_rd_en;
   logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
   logic [VALUE_W-1:0] mem_wr_data, mem_rd_data;

   logic walk_more, hit_now, scan_issue, shift_issue, in_range, is_full, out_free;

   assign walk_more   = (ptr_ff < count_ff);
   assign hit_now     = pend_ff && (mem_rd_data == value_ff);
   assign scan_issue  = walk_more && !hit_now;
   assign shift_issue = walk_more;
   assign in_range    = (CMPW'(index_ff) < CMPW'(count_ff));
   assign is_full     = (count_ff == CW'(CAPACITY));
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign stat.req_code   = type_ff;
   assign stat.scan_hit   = hit_now;
   assign stat.scan_done  = hit_now || (!pend_ff && !walk_more);
   assign stat.shift_done = !shift_issue && !pend_ff;
   assign stat.out_free   = out_free;

   bst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Walk, memory port and table state.
   always_comb begin
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pend_in     = 1'b0;
      pend_pos_in = pend_pos_ff;
      hit_in      = hit_ff;
      hit_pos_in  = hit_pos_ff;
      full_in     = full_ff;
      app_pos_in  = app_pos_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[AW-1:0];
      mem_wr_data = value_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff[AW-1:0];

      if (cmd.load) begin
         ptr_in  = '0;
         hit_in  = 1'b0;
         full_in = 1'b0;
      end

      if (cmd.scan) begin
         if (hit_now) begin
            // Park the pointer just past the match, where a removal starts.
            hit_in     = 1'b1;
            hit_pos_in = pend_pos_ff;
            ptr_in     = CW'(pend_pos_ff) + CW'(1);
         end else if (scan_issue) begin
            mem_rd_en   = 1'b1;
            ptr_in      = ptr_ff + CW'(1);
            pend_in     = 1'b1;
            pend_pos_in = ptr_ff[AW-1:0];
         end
      end

      if (cmd.shift) begin
         if (shift_issue) begin
            mem_rd_en   = 1'b1;
            ptr_in      = ptr_ff + CW'(1);
            pend_in     = 1'b1;
            pend_pos_in = ptr_ff[AW-1:0];
         end
         // The word read from one position lands one position lower.
         if (pend_ff) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pend_pos_ff - AW'(1);
            mem_wr_data = mem_rd_data;
         end
      end

      if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.append) begin
         if (is_full) begin
            full_in = 1'b1;
         end else begin
            mem_wr_en  = 1'b1;
            app_pos_in = count_ff[AW-1:0];
            count_in   = count_ff + CW'(1);
         end
      end

      if (cmd.read) begin
         mem_rd_en   = in_range;
         mem_rd_addr = AW'(index_ff);
      end

      if (cmd.clear) begin
         count_in = '0;
      end
   end

   // Result word.
   always_comb begin
      status_in   = STATUS_OK;
      present_in  = 1'b0;
      position_in = '0;
      entry_in    = '0;
      case (type_ff)
         REQ_APPEND: begin
            if (full_ff) begin
               status_in = STATUS_FULL;
            end else begin
               position_in = POS_W'(app_pos_ff);
            end
         end
         REQ_APPEND_ABSENT: begin
            if (hit_ff) begin
               present_in  = 1'b1;
               position_in = POS_W'(hit_pos_ff);
            end else if (full_ff) begin
               status_in = STATUS_FULL;
            end else begin
               position_in = POS_W'(app_pos_ff);
            end
         end
         REQ_REMOVE, REQ_FIND: begin
            if (hit_ff) begin
               present_in  = 1'b1;
               position_in = POS_W'(hit_pos_ff);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         REQ_READ: begin
            if (in_range) begin
               entry_in    = mem_rd_data;
               position_in = index_ff;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
      hit_pos_ff  <= hit_pos_in;
      app_pos_ff  <= app_pos_in;
      if (cmd.load) begin
         type_ff  <= req_type;
         value_ff <= req_value;
         index_ff <= req_index;
      end
      if (cmd.finish) begin
         status_ff   <= status_in;
         present_ff  <= present_in;
         position_ff <= position_in;
         entry_ff    <= entry_in;
         ecount_ff   <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_present     = present_ff;
   assign rsp_position    = position_ff;
   assign rsp_entry_value = entry_ff;
   assign rsp_entry_count = ecount_ff;

endmodule

`default_nettype wire

// ===== src/bst_controller.sv =====
// ----------------------------------------------------------------------------
// bst_controller
// Sequencer that takes one request at a time and steps the datapath through
// search, shift, append, read or clear, then loads the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_controller import bst_pkg::*; (
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             req_valid,
   output logic                   req_ready,
   input  wire  logic [REQ_W-1:0] req_type,
   input  wire  bst_stat_type     stat,
   output bst_cmd_type            cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_APPEND,
      S_READ,
      S_CLEAR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_type)
                  REQ_APPEND:                           state_in = S_APPEND;
                  REQ_APPEND_ABSENT, REQ_REMOVE, REQ_FIND: state_in = S_SEARCH;
                  REQ_READ:                             state_in = S_READ;
                  REQ_CLEAR:                            state_in = S_CLEAR;
                  default:                              state_in = S_FINISH;
               endcase
            end
         end
         S_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               case (stat.req_code)
                  REQ_APPEND_ABSENT: state_in = stat.scan_hit ? S_FINISH : S_APPEND;
                  REQ_REMOVE:        state_in = stat.scan_hit ? S_SHIFT : S_FINISH;
                  default:           state_in = S_FINISH;
               endcase
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.dec  = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_FINISH;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_FINISH;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // Wait here until the result register can take the new word.
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/bst_result_checker.sv =====
// ----------------------------------------------------------------------------
// bst_result_checker
// Watches both channels of the set table. It keeps its own copy of the table
// and count, works out the result word for each accepted request, and
// compares every accepted result word with the oldest one it is waiting for.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_result_checker import bst_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic [REQ_W-1:0]           req_type,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire logic [INDEX_W-1:0]         req_index,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [STATUS_W-1:0]        rsp_status,
   input  wire logic                       rsp_present,
   input  wire logic [POS_W-1:0]           rsp_position,
   input  wire logic signed [VALUE_W-1:0]  rsp_entry_value,
   input  wire logic [COUNT_W-1:0]         rsp_entry_count,
   output int                              mismatches,
   output int                              outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      present;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] entry_value;
      logic [COUNT_W-1:0]        entry_count;
   } set_outcome_type;

   logic signed [VALUE_W-1:0] shadow_table [CAPACITY];
   int                        shadow_fill;
   set_outcome_type           awaited_outcomes [$];
   int                        fail_tally = 0;
   int                        awaited_depth = 0;

   assign mismatches  = fail_tally;
   assign outstanding = awaited_depth;

   // Applies one request to the shadow table and returns the word it causes.
   function automatic set_outcome_type apply_request(input logic [REQ_W-1:0] kind,
                                                     input logic signed [VALUE_W-1:0] v,
                                                     input logic [INDEX_W-1:0] idx);
      set_outcome_type o;
      int              hit;
      o = '0;
      hit = -1;
      for (int i = 0; i < shadow_fill; i++) begin
         if (hit < 0 && shadow_table[i] == v) hit = i;
      end
      case (kind)
         REQ_APPEND, REQ_APPEND_ABSENT: begin
            if (kind == REQ_APPEND_ABSENT && hit >= 0) begin
               o.present  = 1'b1;
               o.position = hit[POS_W-1:0];
            end else if (shadow_fill >= CAPACITY) begin
               o.status = STATUS_FULL;
            end else begin
               shadow_table[shadow_fill] = v;
               o.position = shadow_fill[POS_W-1:0];
               shadow_fill++;
            end
         end
         REQ_REMOVE, REQ_FIND: begin
            if (hit >= 0) begin
               o.present  = 1'b1;
               o.position = hit[POS_W-1:0];
               if (kind == REQ_REMOVE) begin
                  // Later entries move down by one and keep their order.
                  for (int i = hit; i + 1 < shadow_fill; i++)
                     shadow_table[i] = shadow_table[i + 1];
                  shadow_fill--;
               end
            end else begin
               o.status = STATUS_NOT_FOUND;
            end
         end
         REQ_READ: begin
            if (int'(idx) < shadow_fill) begin
               o.entry_value = shadow_table[idx];
               o.position    = idx;
            end else begin
               o.status = STATUS_RANGE;
            end
         end
         REQ_CLEAR: shadow_fill = 0;
         default: ;
      endcase
      o.entry_count = shadow_fill[COUNT_W-1:0];
      return o;
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, label, want_v, got_v);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      set_outcome_type want;
      if (reset) begin
         shadow_fill = 0;
         awaited_outcomes.delete();
         awaited_depth <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t ns: result word arrived with none expected", $time);
               fail_tally++;
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("present", 32'(want.present), 32'(rsp_present));
               compare_field("position", 32'(want.position), 32'(rsp_position));
               compare_field("entry_value", want.entry_value, rsp_entry_value);
               compare_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_request(req_type, req_value, req_index));
         awaited_depth <= awaited_outcomes.size();
      end
   end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the set table: a short directed pass over the
// edge cases, then random episodes, some of which fill the table to capacity.
// Both sides idle at random. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import bst_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'h7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VAL_ONES = 32'hffff_ffff;
   localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;

   localparam int RANDOM_WORDS = 1050;
   localparam int DRAIN_CYCLES = 300;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [REQ_W-1:0]           req_type = REQ_APPEND;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic [INDEX_W-1:0]         req_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_present;
   logic [POS_W-1:0]           rsp_position;
   logic signed [VALUE_W-1:0]  rsp_entry_value;
   logic [COUNT_W-1:0]         rsp_entry_count;
   int                         mismatches;
   int                         outstanding;

   bit                         req_calm = 1'b0;
   bit                         rsp_calm = 1'b0;
   int                         stall_left = 0;
   int                         calm_left = 0;
   int                         words_sent = 0;
   logic signed [VALUE_W-1:0]  value_pool [6];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bounded_set_table dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_value, .req_index,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_present, .rsp_position,
      .rsp_entry_value, .rsp_entry_count
   );

   bst_result_checker result_watch (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_value, .req_index,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_present, .rsp_position,
      .rsp_entry_value, .rsp_entry_count,
      .mismatches, .outstanding
   );

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return value_pool[r];
      if (r < 8) return $urandom;
      case ($urandom_range(0, 3))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return VAL_ONES;
         default: return VAL_ZERO;
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return INDEX_W'($urandom_range(0, 15));
      if (r < 9) return INDEX_W'($urandom_range(0, 63));
      return INDEX_W'($urandom_range(0, 127));
   endfunction

   function automatic logic [REQ_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return REQ_APPEND;
      if (r < 45) return REQ_APPEND_ABSENT;
      if (r < 65) return REQ_REMOVE;
      if (r < 79) return REQ_FIND;
      if (r < 94) return REQ_READ;
      if (r < 96) return REQ_CLEAR;
      return $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
   endfunction

   // A small pool per episode so that searches hit often.
   task automatic refresh_pool();
      foreach (value_pool[i])
         value_pool[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15) - 8;
   endtask

   // Offers one word and returns at the edge where it is taken.
   task automatic send_word(input logic [REQ_W-1:0] kind,
                            input logic signed [VALUE_W-1:0] v,
                            input logic [INDEX_W-1:0] idx);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= v;
      req_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_random_word();
      send_word(pick_kind(), pick_value(), pick_index());
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= pick_gap(rsp_calm);
      end
      if (calm_left == 0) begin
         rsp_calm  <= ($urandom_range(0, 3) == 0);
         calm_left <= $urandom_range(50, 400);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   initial begin
      int episode;
      int run_len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty table: every search misses and every index is out of range.
      send_word(REQ_READ, VAL_ZERO, 7'd0);
      send_word(REQ_FIND, VAL_ZERO, 7'd0);
      send_word(REQ_REMOVE, VAL_MAX, 7'd0);
      send_word(REQ_APPEND, VAL_MIN, 7'd0);
      send_word(REQ_APPEND, VAL_MAX, 7'd0);
      send_word(REQ_APPEND, VAL_ONES, 7'd0);
      send_word(REQ_APPEND, VAL_ZERO, 7'd0);
      send_word(REQ_APPEND_ABSENT, VAL_ONES, 7'd0);
      send_word(REQ_APPEND_ABSENT, 32'sd5, 7'd0);
      send_word(REQ_FIND, VAL_MAX, 7'd0);
      send_word(REQ_READ, VAL_ZERO, 7'd1);
      send_word(REQ_READ, VAL_ZERO, 7'd4);
      send_word(REQ_READ, VAL_ZERO, 7'd5);
      send_word(REQ_READ, VAL_ZERO, 7'd127);
      // Removal from the middle, the front and the back.
      send_word(REQ_REMOVE, VAL_ONES, 7'd0);
      send_word(REQ_REMOVE, VAL_MIN, 7'd0);
      send_word(REQ_REMOVE, 32'sd5, 7'd0);
      // Duplicates: the first equal entry is the one found and removed.
      send_word(REQ_APPEND, VAL_ZERO, 7'd0);
      send_word(REQ_FIND, VAL_ZERO, 7'd0);
      send_word(REQ_REMOVE, VAL_ZERO, 7'd0);
      send_word(REQ_SPARE_LO, VAL_MAX, 7'd127);
      send_word(REQ_SPARE_HI, VAL_MIN, 7'd64);
      send_word(REQ_CLEAR, VAL_ONES, 7'd127);
      send_word(REQ_READ, VAL_ZERO, 7'd0);
      send_word(REQ_FIND, VAL_ZERO, 7'd0);

      episode = 0;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         refresh_pool();
         req_calm = ($urandom_range(0, 3) == 0);
         if (episode % 5 == 1) begin
            // Fill past capacity, work on the full table, then empty it.
            repeat (CAPACITY_DEF + 2) send_word(REQ_APPEND, pick_value(), pick_index());
            repeat ($urandom_range(8, 16)) send_random_word();
            send_word(REQ_CLEAR, pick_value(), pick_index());
         end else begin
            run_len = $urandom_range(30, 60);
            repeat (run_len) send_random_word();
         end
         episode++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
